// ===== design/dtq_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the deadline compare for the delayed message timer queue.
package dtq_pkg;

    // Queue size and time base.
    localparam int unsigned DEPTH            = 16;
    localparam int unsigned TICKS_PER_SECOND = 1000000;
    localparam int unsigned MAX_RESULTS      = 16;

    // Fixed field widths.
    localparam int unsigned SEC_W  = 32;
    localparam int unsigned SUB_W  = 20;
    localparam int unsigned HDL_W  = 16;
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam int unsigned REL_W  = $clog2(MAX_RESULTS);
    localparam int unsigned REM_W  = SUB_W + 1;

    // Reciprocal of the tick rate, scaled by 2^32, for the quotient estimate.
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / TICKS_PER_SECOND);
    localparam logic [31:0] TPS   = 32'(TICKS_PER_SECOND);

    // Result kinds.
    localparam logic [1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [1:0] KIND_DROPPED  = 2'd1;
    localparam logic [1:0] KIND_RELEASED = 2'd2;
    localparam logic [1:0] KIND_NONE_DUE = 2'd3;

    // Request opcodes.
    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    // One queued delivery.
    typedef struct packed {
        logic [SEC_W-1:0] due_sec;
        logic [SUB_W-1:0] due_sub;
        logic [HDL_W-1:0] target;
        logic [HDL_W-1:0] message;
    } t_entry;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic   insert;
        logic   pop;
        t_entry entry;
    } t_cell_ctl;

    // True when deadline a is strictly later than deadline b.
    function automatic logic later_than(input logic [SEC_W-1:0] a_sec,
                                        input logic [SUB_W-1:0] a_sub,
                                        input logic [SEC_W-1:0] b_sec,
                                        input logic [SUB_W-1:0] b_sub);
        logic res;
        if (a_sec != b_sec) begin
            res = (a_sec > b_sec);
        end else begin
            res = (a_sub > b_sub);
        end
        return res;
    endfunction

endpackage

// ===== design/delayed_message_timer_queue.sv =====
`timescale 1ns / 1ps
// Top level of the delayed message timer queue: sequencer, deadline arithmetic and cell row.
//
// The queue keeps up to DEPTH deliveries in a row of cells sorted by deadline, earliest
// in cell 0. A schedule request goes through S_MUL, S_REM and S_FIX for the
// reciprocal-multiply split of the delay into seconds and ticks, S_SUM to add it to the
// current time, and S_INS, in which every cell compares against the new deadline and
// the row shifts to open its slot when the output register is free. A schedule into a
// full queue gives a drop result instead. A tick request loads the new time and then
// releases one due entry per cycle from cell 0 while the output register can take it,
// up to sixteen, with the row shifting left each time; a tick with nothing due gives a
// single result. A new request is taken once the previous one has delivered its last
// result into the output register, even while that result still waits.
module delayed_message_timer_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_op,
    input  logic [31:0]               i_delay_us,
    input  logic [15:0]               i_target_id,
    input  logic [15:0]               i_message_ref,
    input  logic [31:0]               i_now_sec,
    input  logic [19:0]               i_now_sub,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_kind,
    output logic [15:0]               o_out_target,
    output logic [15:0]               o_out_message,
    output logic                      o_last,
    output logic [4:0]                o_pending
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_REM  = 8'b0000_0100,
        S_FIX  = 8'b0000_1000,
        S_SUM  = 8'b0001_0000,
        S_INS  = 8'b0010_0000,
        S_DROP = 8'b0100_0000,
        S_REL  = 8'b1000_0000
    } t_state;

    t_state                              r_state, n_state;
    logic [dtq_pkg::CNT_W-1:0]           r_count, n_count;
    logic [dtq_pkg::REL_W-1:0]           r_rel_n, n_rel_n;
    logic [dtq_pkg::SEC_W-1:0]           r_clock_sec, n_clock_sec;
    logic [dtq_pkg::SUB_W-1:0]           r_clock_sub, n_clock_sub;

    // Captured request payload.
    logic [31:0]                         r_delay;
    logic [dtq_pkg::HDL_W-1:0]           r_target;
    logic [dtq_pkg::HDL_W-1:0]           r_message;

    // Deadline arithmetic registers.
    logic [63:0]                         r_prod;
    logic [31:0]                         r_quo;
    logic [dtq_pkg::REM_W-1:0]           r_rem;
    logic [dtq_pkg::SEC_W-1:0]           r_new_sec;
    logic [dtq_pkg::SUB_W-1:0]           r_new_sub;

    // Output register.
    logic                                r_out_valid;
    logic [1:0]                          r_kind, n_kind;
    logic [dtq_pkg::HDL_W-1:0]           r_out_target, n_out_target;
    logic [dtq_pkg::HDL_W-1:0]           r_out_message, n_out_message;
    logic                                r_last, n_last;
    logic [dtq_pkg::CNT_W-1:0]           r_pending, n_pending;

    logic                                in_accept;
    logic                                can_load;
    logic                                out_load;
    logic                                head_due;
    logic                                next_due;
    logic [dtq_pkg::REM_W-1:0]           sum_sub;
    logic [dtq_pkg::SUB_W-1:0]           sat_sub;
    dtq_pkg::t_cell_ctl                  cell_ctl;
    dtq_pkg::t_entry                     cell_entry [dtq_pkg::DEPTH];
    logic                                cell_gt    [dtq_pkg::DEPTH];

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign can_load   = !r_out_valid || i_out_ready;

    // A tick time beyond the last sub-second tick saturates.
    assign sat_sub = (32'(i_now_sub) >= dtq_pkg::TPS) ? dtq_pkg::SUB_W'(dtq_pkg::TPS - 32'd1)
                                                       : i_now_sub;

    // Release lookahead: the head is due now, and the entry behind it is due as well.
    assign head_due = (r_count != '0) &&
                      !dtq_pkg::later_than(cell_entry[0].due_sec, cell_entry[0].due_sub,
                                           r_clock_sec, r_clock_sub);
    assign next_due = (r_count > dtq_pkg::CNT_W'(1)) &&
                      !dtq_pkg::later_than(cell_entry[1].due_sec, cell_entry[1].due_sub,
                                           r_clock_sec, r_clock_sub) &&
                      (r_rel_n != dtq_pkg::REL_W'(dtq_pkg::MAX_RESULTS - 1));

    // Sequencer and result generation.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_rel_n       = r_rel_n;
        n_clock_sec   = r_clock_sec;
        n_clock_sub   = r_clock_sub;
        out_load      = 1'b0;
        n_kind        = r_kind;
        n_out_target  = r_out_target;
        n_out_message = r_out_message;
        n_last        = r_last;
        n_pending     = r_pending;
        cell_ctl.insert = 1'b0;
        cell_ctl.pop    = 1'b0;
        cell_ctl.entry  = '{due_sec: r_new_sec, due_sub: r_new_sub,
                            target: r_target, message: r_message};
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_op == dtq_pkg::OP_TICK) begin
                        n_clock_sec = i_now_sec;
                        n_clock_sub = sat_sub;
                        n_rel_n     = '0;
                        n_state     = S_REL;
                    end else if (r_count == dtq_pkg::CNT_W'(dtq_pkg::DEPTH)) begin
                        n_state = S_DROP;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_state = S_REM;
            end
            S_REM: begin
                n_state = S_FIX;
            end
            S_FIX: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                n_state = S_INS;
            end
            S_INS: begin
                if (can_load) begin
                    cell_ctl.insert = 1'b1;
                    n_count         = r_count + dtq_pkg::CNT_W'(1);
                    out_load        = 1'b1;
                    n_kind          = dtq_pkg::KIND_ACCEPTED;
                    n_out_target    = '0;
                    n_out_message   = '0;
                    n_last          = 1'b1;
                    n_pending       = r_count + dtq_pkg::CNT_W'(1);
                    n_state         = S_IDLE;
                end
            end
            S_DROP: begin
                if (can_load) begin
                    out_load      = 1'b1;
                    n_kind        = dtq_pkg::KIND_DROPPED;
                    n_out_target  = '0;
                    n_out_message = '0;
                    n_last        = 1'b1;
                    n_pending     = r_count;
                    n_state       = S_IDLE;
                end
            end
            S_REL: begin
                if (can_load) begin
                    out_load = 1'b1;
                    if (head_due) begin
                        cell_ctl.pop  = 1'b1;
                        n_count       = r_count - dtq_pkg::CNT_W'(1);
                        n_rel_n       = r_rel_n + dtq_pkg::REL_W'(1);
                        n_kind        = dtq_pkg::KIND_RELEASED;
                        n_out_target  = cell_entry[0].target;
                        n_out_message = cell_entry[0].message;
                        n_last        = !next_due;
                        n_pending     = r_count - dtq_pkg::CNT_W'(1);
                        if (!next_due) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_kind        = dtq_pkg::KIND_NONE_DUE;
                        n_out_target  = '0;
                        n_out_message = '0;
                        n_last        = 1'b1;
                        n_pending     = r_count;
                        n_state       = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rel_n     <= '0;
            r_clock_sec <= '0;
            r_clock_sub <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rel_n     <= n_rel_n;
            r_clock_sec <= n_clock_sec;
            r_clock_sub <= n_clock_sub;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        r_kind        <= n_kind;
        r_out_target  <= n_out_target;
        r_out_message <= n_out_message;
        r_last        <= n_last;
        r_pending     <= n_pending;
    end

    // Capture of the schedule payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_delay   <= i_delay_us;
            r_target  <= i_target_id;
            r_message <= i_message_ref;
        end
    end

    // Deadline arithmetic: quotient estimate, remainder, correction, then add to the clock.
    assign sum_sub = dtq_pkg::REM_W'(r_clock_sub) + r_rem;

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod <= 64'(r_delay) * 64'(dtq_pkg::RECIP);
        end
        if (r_state == S_REM) begin
            r_quo <= r_prod[63:32];
        end
        if (r_state == S_FIX) begin
            // The estimate is low by at most one.
            if (32'(r_rem) >= dtq_pkg::TPS) begin
                r_rem <= r_rem - dtq_pkg::REM_W'(dtq_pkg::TPS);
                r_quo <= r_quo + 32'd1;
            end
        end else if (r_state == S_REM) begin
            r_rem <= dtq_pkg::REM_W'(r_delay - (r_prod[63:32] * dtq_pkg::TPS));
        end
        if (r_state == S_SUM) begin
            if (32'(sum_sub) >= dtq_pkg::TPS) begin
                r_new_sub <= dtq_pkg::SUB_W'(sum_sub - dtq_pkg::REM_W'(dtq_pkg::TPS));
                r_new_sec <= r_clock_sec + r_quo + 32'd1;
            end else begin
                r_new_sub <= dtq_pkg::SUB_W'(sum_sub);
                r_new_sec <= r_clock_sec + r_quo;
            end
        end
    end

    // Row of queue cells.
    for (genvar gi = 0; gi < dtq_pkg::DEPTH; gi++) begin : g_cell
        dtq_pkg::t_entry left_entry;
        dtq_pkg::t_entry right_entry;
        logic            left_gt;
        logic            slot_valid;

        if (gi == 0) begin : g_first
            assign left_entry = cell_ctl.entry;
            assign left_gt    = 1'b0;
        end else begin : g_inner
            assign left_entry = cell_entry[gi-1];
            assign left_gt    = cell_gt[gi-1];
        end

        if (gi == dtq_pkg::DEPTH - 1) begin : g_last
            assign right_entry = cell_entry[gi];
        end else begin : g_body
            assign right_entry = cell_entry[gi+1];
        end

        assign slot_valid = (r_count > dtq_pkg::CNT_W'(gi));

        dtq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (cell_ctl),
            .i_valid   (slot_valid),
            .i_left    (left_entry),
            .i_left_gt (left_gt),
            .i_right   (right_entry),
            .o_entry   (cell_entry[gi]),
            .o_gt      (cell_gt[gi])
        );
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_out_target  = r_out_target;
    assign o_out_message = r_out_message;
    assign o_last        = r_last;
    assign o_pending     = 5'(r_pending);

    // The fill count never passes the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dtq_pkg::CNT_W'(dtq_pkg::DEPTH))
        else $error("queue count exceeds depth");

    // Each released entry leaves the queue one shorter.
    a_release_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && n_kind == dtq_pkg::KIND_RELEASED)
        |=> r_count == $past(r_count) - dtq_pkg::CNT_W'(1))
        else $error("release did not shorten the queue");

    // A result that is not the last keeps the release scan running.
    a_not_last_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !n_last) |=> r_state == S_REL)
        else $error("scan stopped before the final result");

    // A schedule is only accepted into the queue while there is room.
    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_ctl.insert |-> r_count < dtq_pkg::CNT_W'(dtq_pkg::DEPTH))
        else $error("insert into a full queue");

endmodule

// ===== design/dtq_cell.sv =====
`timescale 1ns / 1ps
// One slot of the sorted queue: holds an entry and shifts it toward either neighbor.
module dtq_cell (
    input  logic               i_clk,
    input  dtq_pkg::t_cell_ctl i_ctl,
    input  logic               i_valid,
    input  dtq_pkg::t_entry    i_left,
    input  logic               i_left_gt,
    input  dtq_pkg::t_entry    i_right,
    output dtq_pkg::t_entry    o_entry,
    output logic               o_gt
);

    dtq_pkg::t_entry r_entry;
    dtq_pkg::t_entry n_entry;

    // An empty slot, or one due strictly after the new entry, makes room for it.
    always_comb begin
        o_gt = !i_valid || dtq_pkg::later_than(r_entry.due_sec, r_entry.due_sub,
                                               i_ctl.entry.due_sec,
                                               i_ctl.entry.due_sub);
    end

    // On insert, slots past the insertion point take their left neighbor; on pop,
    // every slot takes its right neighbor.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.insert && o_gt) begin
            n_entry = i_left_gt ? i_left : i_ctl.entry;
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
